// File: rtl/core/wprs_pkg.sv
// Package for the window plane region splitter.
// Holds the rectangle and region types, plane codes and register indexes.
// No dependencies; the cfg, calc, emit and top modules and the bench import it.
package wprs_pkg;

    localparam int unsigned COORD_W = 12;
    localparam int unsigned SPLIT_W = 16;
    localparam int unsigned MAX_REGIONS = 4;
    localparam int unsigned IDX_W = 2;
    localparam int unsigned ADDR_W = 5;

    // Plane codes carried in plane_id.
    localparam logic [1:0] PLANE_B = 2'd0;
    localparam logic [1:0] PLANE_A = 2'd1;
    localparam logic [1:0] PLANE_W = 2'd2;

    // Register indexes (byte address divided by four).
    localparam logic [2:0] REG_SPLIT_X = 3'd0;
    localparam logic [2:0] REG_WINDOW_RIGHT = 3'd1;
    localparam logic [2:0] REG_SPLIT_Y = 3'd2;
    localparam logic [2:0] REG_WINDOW_BELOW = 3'd3;
    localparam logic [2:0] REG_A_BEHIND = 3'd4;

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] w;
        logic [COORD_W-1:0] h;
    } t_rect;

    typedef struct packed {
        logic [1:0] plane_id;
        t_rect      rect;
    } t_entry;

    typedef struct packed {
        logic [1:0] plane_id;
        t_rect      rect;
        logic       last;
    } t_region;

    typedef struct packed {
        logic [SPLIT_W-1:0] split_x;
        logic               window_right;
        logic [SPLIT_W-1:0] split_y;
        logic               window_below;
        logic               a_behind_window;
    } t_cfg;

endpackage

// File: rtl/core/wprs_in_if.sv
// Input channel of the region splitter: one beat carries a screen rectangle.
// Depends on nothing; field widths are fixed at 12 bits.
interface wprs_in_if;
    logic        valid;
    logic        ready;
    logic [11:0] screen_x;
    logic [11:0] screen_y;
    logic [11:0] screen_width;
    logic [11:0] screen_height;

    modport source (output valid, output screen_x, output screen_y,
                    output screen_width, output screen_height, input ready);
    modport sink (input valid, input screen_x, input screen_y,
                  input screen_width, input screen_height, output ready);
endinterface

// File: rtl/core/wprs_out_if.sv
// Output channel of the region splitter: one beat carries one region.
// Depends on nothing; field widths follow the region format.
interface wprs_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  plane_id;
    logic [11:0] region_x;
    logic [11:0] region_y;
    logic [11:0] region_width;
    logic [11:0] region_height;
    logic        last_region;

    modport source (output valid, output plane_id, output region_x, output region_y,
                    output region_width, output region_height, output last_region,
                    input ready);
    modport sink (input valid, input plane_id, input region_x, input region_y,
                  input region_width, input region_height, input last_region,
                  output ready);
endinterface

// File: rtl/core/wprs_cfg.sv
// APB-style configuration registers of the region splitter.
// Depends on wprs_pkg for the register indexes and the t_cfg type.
module wprs_cfg (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [wprs_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]               pwdata,
    output logic [31:0]               prdata,
    output logic                      pready,
    output wprs_pkg::t_cfg            o_cfg
);
    import wprs_pkg::*;

    t_cfg       r_cfg;
    logic       wr_en;
    logic [2:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[ADDR_W-1:2];
    assign o_cfg   = r_cfg;

    // Register writes in the access cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_SPLIT_X:      r_cfg.split_x <= pwdata[SPLIT_W-1:0];
                REG_WINDOW_RIGHT: r_cfg.window_right <= pwdata[0];
                REG_SPLIT_Y:      r_cfg.split_y <= pwdata[SPLIT_W-1:0];
                REG_WINDOW_BELOW: r_cfg.window_below <= pwdata[0];
                REG_A_BEHIND:     r_cfg.a_behind_window <= pwdata[0];
                default: ;
            endcase
        end
    end

    // Read-back of the addressed register.
    always_comb begin
        unique case (reg_idx)
            REG_SPLIT_X:      prdata = {16'd0, r_cfg.split_x};
            REG_WINDOW_RIGHT: prdata = {31'd0, r_cfg.window_right};
            REG_SPLIT_Y:      prdata = {16'd0, r_cfg.split_y};
            REG_WINDOW_BELOW: prdata = {31'd0, r_cfg.window_below};
            REG_A_BEHIND:     prdata = {31'd0, r_cfg.a_behind_window};
            default:          prdata = '0;
        endcase
    end

endmodule

// File: rtl/core/wprs_calc.sv
// Combinational split of one screen rectangle into its list of regions.
// Depends on wprs_pkg for the rectangle, entry and configuration types.
module wprs_calc (
    input  wprs_pkg::t_rect               i_full,
    input  wprs_pkg::t_cfg                i_cfg,
    output wprs_pkg::t_entry [3:0]        o_list,
    output logic [wprs_pkg::IDX_W-1:0]    o_last_idx
);
    import wprs_pkg::*;

    logic [COORD_W-1:0] sx;
    logic [COORD_W-1:0] sy;
    t_rect              ra;
    t_rect              inv;
    t_rect              w1;
    t_rect              w2;
    logic               ra_empty;
    logic               ra_same;
    logic               a_en;
    logic [1:0]         win_cnt;
    t_entry             e_b;
    t_entry             e_a;
    t_entry             e_w1;
    t_entry             e_w2;

    // Clamp the split positions to the screen size.
    always_comb begin
        sx = (i_cfg.split_x > {4'd0, i_full.w}) ? i_full.w : i_cfg.split_x[COORD_W-1:0];
        sy = (i_cfg.split_y > {4'd0, i_full.h}) ? i_full.h : i_cfg.split_y[COORD_W-1:0];
    end

    // Plane A region and the complementary window extents.
    always_comb begin
        ra  = i_full;
        inv = '0;
        if (i_cfg.window_right) begin
            ra.w  = sx;
            inv.x = sx;
            inv.w = i_full.w - sx;
        end else begin
            inv.w = sx;
            ra.x  = sx;
            ra.w  = i_full.w - sx;
        end
        if (i_cfg.window_below) begin
            ra.h  = sy;
            inv.y = sy;
            inv.h = i_full.h - sy;
        end else begin
            inv.h = sy;
            ra.y  = sy;
            ra.h  = i_full.h - sy;
        end
    end

    assign ra_empty = (ra.w == '0) || (ra.h == '0);
    assign ra_same  = (ra == i_full);
    assign a_en     = i_cfg.a_behind_window || !ra_empty;

    // Window rectangles: none, full screen, a strip, or an upper and a lower part.
    always_comb begin
        w1 = i_full;
        w2 = i_full;
        priority if (ra_same) begin
            win_cnt = 2'd0;
        end else if (ra_empty) begin
            win_cnt = 2'd1;
        end else if (ra.w == i_full.w) begin
            w1.y    = inv.y;
            w1.h    = inv.h;
            win_cnt = 2'd1;
        end else if (ra.h == i_full.h) begin
            w1.x    = inv.x;
            w1.w    = inv.w;
            win_cnt = 2'd1;
        end else if (ra.y == '0) begin
            // Plane A at the top: narrow upper part, full-width lower part.
            w1.x    = inv.x;
            w1.w    = inv.w;
            w1.h    = ra.h;
            w2.y    = inv.y;
            w2.h    = inv.h;
            win_cnt = 2'd2;
        end else begin
            // Plane A lower down: full-width upper part, narrow lower part.
            w1.h    = inv.h;
            w2.x    = inv.x;
            w2.w    = inv.w;
            w2.y    = ra.y;
            w2.h    = ra.h;
            win_cnt = 2'd2;
        end
    end

    // Pack the list in output order; entries past the last index are unused.
    always_comb begin
        e_b.plane_id  = PLANE_B;
        e_b.rect      = i_full;
        e_a.plane_id  = PLANE_A;
        e_a.rect      = i_cfg.a_behind_window ? i_full : ra;
        e_w1.plane_id = PLANE_W;
        e_w1.rect     = w1;
        e_w2.plane_id = PLANE_W;
        e_w2.rect     = w2;
        o_list[0] = e_b;
        o_list[1] = a_en ? e_a : e_w1;
        o_list[2] = a_en ? e_w1 : e_w2;
        o_list[3] = e_w2;
        o_last_idx = {1'b0, a_en} + win_cnt;
    end

endmodule

// File: rtl/core/wprs_emit.sv
// Region list buffer and output register: sends one region beat per cycle while the receiver is ready.
// Depends on wprs_pkg for the entry and region types.
module wprs_emit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_load,
    input  wprs_pkg::t_entry [3:0]         i_list,
    input  logic [wprs_pkg::IDX_W-1:0]     i_last_idx,
    output logic                           o_free,
    output logic                           o_valid,
    input  logic                           i_ready,
    output wprs_pkg::t_region              o_region
);
    import wprs_pkg::*;

    t_entry [3:0]     r_list;
    logic [IDX_W-1:0] r_idx;
    logic [IDX_W-1:0] r_last_idx;
    logic             r_busy;
    logic             r_out_valid;
    t_region          r_out;
    logic             out_take;
    logic             at_last;

    assign out_take = !r_out_valid || i_ready;
    assign at_last  = (r_idx == r_last_idx);
    assign o_free   = !r_busy || (out_take && at_last);
    assign o_valid  = r_out_valid;
    assign o_region = r_out;

    // Control: list occupancy, read index and output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (out_take) begin
                r_out_valid <= r_busy;
            end
            if (i_load) begin
                r_busy <= 1'b1;
                r_idx  <= '0;
            end else if (out_take && r_busy) begin
                if (at_last) begin
                    r_busy <= 1'b0;
                end else begin
                    r_idx <= r_idx + 1'b1;
                end
            end
        end
    end

    // Payload: the list itself and the region in the output register.
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_list     <= i_list;
            r_last_idx <= i_last_idx;
        end
        if (out_take && r_busy) begin
            r_out.plane_id <= r_list[r_idx].plane_id;
            r_out.rect     <= r_list[r_idx].rect;
            r_out.last     <= at_last;
        end
    end

endmodule

// File: rtl/core/window_plane_region_split_top.sv
// Window plane region splitter, top level: input register, split logic,
// region buffer and APB configuration. Depends on wprs_pkg, wprs_in_if,
// wprs_out_if, wprs_cfg, wprs_calc and wprs_emit.
//
// Each screen rectangle beat yields one to four region beats, in the order
// plane B, plane A (when present), then up to two window regions; the final
// one carries last_region. Regions leave one per cycle from the output
// register while the receiver is ready, read through the single region
// read port of the list buffer. A new screen is taken in the cycle the
// previous list sends its last region. A screen passes through the input
// register, list buffer and output register. The user must write registers
// over APB only while no screen is in flight; the block does not enforce it.
module window_plane_region_split_top (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [wprs_pkg::ADDR_W-1:0]    paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready,
    wprs_in_if.sink                        i_screen,
    wprs_out_if.source                     o_region
);
    import wprs_pkg::*;

    t_cfg             cfg;
    t_rect            r_full;
    logic             r_in_valid;
    logic             emit_free;
    logic             load;
    t_entry [3:0]     list;
    logic [IDX_W-1:0] last_idx;
    t_region          region;

    wprs_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // Input register: holds one screen until the region buffer takes it.
    assign load           = r_in_valid && emit_free;
    assign i_screen.ready = !r_in_valid || emit_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_screen.ready) begin
            r_in_valid <= i_screen.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_screen.ready && i_screen.valid) begin
            r_full.x <= i_screen.screen_x;
            r_full.y <= i_screen.screen_y;
            r_full.w <= i_screen.screen_width;
            r_full.h <= i_screen.screen_height;
        end
    end

    wprs_calc u_calc (
        .i_full     (r_full),
        .i_cfg      (cfg),
        .o_list     (list),
        .o_last_idx (last_idx)
    );

    wprs_emit u_emit (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (load),
        .i_list     (list),
        .i_last_idx (last_idx),
        .o_free     (emit_free),
        .o_valid    (o_region.valid),
        .i_ready    (o_region.ready),
        .o_region   (region)
    );

    // Output beat fields.
    assign o_region.plane_id      = region.plane_id;
    assign o_region.region_x      = region.rect.x;
    assign o_region.region_y      = region.rect.y;
    assign o_region.region_width  = region.rect.w;
    assign o_region.region_height = region.rect.h;
    assign o_region.last_region   = region.last;

endmodule

// File: bench/tb_window_plane_region_split_top.sv
// Self-checking bench for window_plane_region_split_top: screens go in, region beats are
// compared with a predictor. Depends on wprs_pkg, wprs_in_if, wprs_out_if and the block.
module tb_window_plane_region_split_top;
    timeunit 1ns;
    timeprecision 1ps;

    import wprs_pkg::*;

    localparam int unsigned HOLD_CYCLES = 400;
    localparam int unsigned QUIET_LIMIT = 3000;
    localparam int unsigned TAIL_CYCLES = 8;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    wprs_in_if  screen_if ();
    wprs_out_if region_if ();

    window_plane_region_split_top u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .i_screen (screen_if),
        .o_region (region_if)
    );

    // Mirror of the register file and the regions still owed by the block.
    t_cfg        layout;
    t_region     expected_regions[$];
    bit          no_idle = 1'b0;
    bit          hold_toggle = 1'b0;
    bit          hold_seen;
    int unsigned hold_left;
    int unsigned quiet_cycles = 0;
    int unsigned failures = 0;
    int unsigned screens_sent = 0;
    int unsigned regions_checked = 0;
    int unsigned window_pairs = 0;
    int unsigned layouts_used = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Works out the regions one screen yields under the current layout.
    function automatic void predict_regions(input t_rect full);
        t_rect              ra;
        t_rect              inv;
        t_rect              w1;
        t_rect              w2;
        logic [COORD_W-1:0] sx;
        logic [COORD_W-1:0] sy;
        t_region            list[MAX_REGIONS];
        int                 n;
        n  = 0;
        sx = (layout.split_x > full.w) ? full.w : layout.split_x[COORD_W-1:0];
        sy = (layout.split_y > full.h) ? full.h : layout.split_y[COORD_W-1:0];
        ra  = full;
        inv = '0;
        if (layout.window_right) begin
            ra.w  = sx;
            inv.x = sx;
            inv.w = full.w - sx;
        end else begin
            inv.w = sx;
            ra.x  = sx;
            ra.w  = full.w - sx;
        end
        if (layout.window_below) begin
            ra.h  = sy;
            inv.y = sy;
            inv.h = full.h - sy;
        end else begin
            inv.h = sy;
            ra.y  = sy;
            ra.h  = full.h - sy;
        end
        list[n] = {PLANE_B, full, 1'b0};
        n++;
        if (layout.a_behind_window || (ra.w != '0 && ra.h != '0)) begin
            list[n] = {PLANE_A, (layout.a_behind_window ? full : ra), 1'b0};
            n++;
        end
        // The window fills whatever plane A leaves uncovered.
        if (ra != full) begin
            w1 = full;
            if (ra.w == '0 || ra.h == '0) begin
                list[n] = {PLANE_W, w1, 1'b0};
                n++;
            end else if (ra.w == full.w) begin
                w1.y = inv.y;
                w1.h = inv.h;
                list[n] = {PLANE_W, w1, 1'b0};
                n++;
            end else if (ra.h == full.h) begin
                w1.x = inv.x;
                w1.w = inv.w;
                list[n] = {PLANE_W, w1, 1'b0};
                n++;
            end else begin
                w2 = full;
                if (ra.y == '0) begin
                    w1.x = inv.x;
                    w1.w = inv.w;
                    w1.h = ra.h;
                    w2.y = inv.y;
                    w2.h = inv.h;
                end else begin
                    w1.h = inv.h;
                    w2.x = inv.x;
                    w2.w = inv.w;
                    w2.y = ra.y;
                    w2.h = ra.h;
                end
                list[n] = {PLANE_W, w1, 1'b0};
                n++;
                list[n] = {PLANE_W, w2, 1'b0};
                n++;
                window_pairs++;
            end
        end
        for (int i = 0; i < n; i++) begin
            list[i].last = (i == n - 1);
            expected_regions.push_back(list[i]);
        end
    endfunction

    function automatic logic [SPLIT_W-1:0] rand_split();
        case ($urandom_range(7))
            0: return '0;
            1: return '1;
            2: return SPLIT_W'($urandom_range(65535));
            default: return SPLIT_W'($urandom_range(480));
        endcase
    endfunction

    function automatic logic [COORD_W-1:0] rand_dim();
        case ($urandom_range(9))
            0: return '0;
            1: return '1;
            2, 3: return COORD_W'($urandom_range(4095));
            default: return COORD_W'($urandom_range(1, 512));
        endcase
    endfunction

    function automatic logic [COORD_W-1:0] rand_origin();
        return ($urandom_range(99) < 30) ? '0 : COORD_W'($urandom_range(4095));
    endfunction

    // Offers one screen beat, with occasional idle cycles beforehand, and records
    // the regions it should produce once it is taken.
    task automatic send_screen(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
                               input logic [COORD_W-1:0] w, input logic [COORD_W-1:0] h);
        while (!no_idle && $urandom_range(99) < 29) begin
            screen_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        screen_if.valid         <= 1'b1;
        screen_if.screen_x      <= x;
        screen_if.screen_y      <= y;
        screen_if.screen_width  <= w;
        screen_if.screen_height <= h;
        @(posedge i_clk);
        while (!screen_if.ready) @(posedge i_clk);
        predict_regions({x, y, w, h});
        screens_sent++;
    endtask

    task automatic send_random_screen();
        send_screen(rand_origin(), rand_origin(), rand_dim(), rand_dim());
    endtask

    // Stops offering screens and waits until every owed region has come out.
    task automatic drain_regions();
        screen_if.valid <= 1'b0;
        while (expected_regions.size() != 0) @(posedge i_clk);
    endtask

    // One APB write: setup cycle, then access cycle until pready.
    task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        case (idx)
            REG_SPLIT_X:      layout.split_x = value[SPLIT_W-1:0];
            REG_WINDOW_RIGHT: layout.window_right = value[0];
            REG_SPLIT_Y:      layout.split_y = value[SPLIT_W-1:0];
            REG_WINDOW_BELOW: layout.window_below = value[0];
            REG_A_BEHIND:     layout.a_behind_window = value[0];
            default: ;
        endcase
    endtask

    // Reprograms the whole layout once the block has gone idle.
    task automatic set_layout(input logic [SPLIT_W-1:0] sx, input logic right,
                              input logic [SPLIT_W-1:0] sy, input logic below,
                              input logic behind);
        drain_regions();
        write_reg(REG_SPLIT_X, 32'(sx));
        write_reg(REG_WINDOW_RIGHT, 32'(right));
        write_reg(REG_SPLIT_Y, 32'(sy));
        write_reg(REG_WINDOW_BELOW, 32'(below));
        write_reg(REG_A_BEHIND, 32'(behind));
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        layouts_used++;
    endtask

    // Registers at reset: plane A covers the whole screen, and an empty screen
    // gives plane B alone.
    task automatic test_reset_layout();
        send_screen(12'd0, 12'd0, 12'd320, 12'd224);
        send_screen('1, '1, '1, '1);
        send_screen('0, '0, '0, '0);
    endtask

    // Split positions far beyond the screen are clamped to its edges.
    task automatic test_clamped_splits();
        set_layout('1, 1'b1, '1, 1'b1, 1'b0);
        send_screen(12'd10, 12'd20, 12'd320, 12'd224);
        send_screen('0, '0, '1, 12'd1);
    endtask

    // Plane A squeezed to nothing: the window takes the full screen.
    task automatic test_empty_plane_a();
        set_layout('0, 1'b1, 16'd100, 1'b1, 1'b1);
        send_screen(12'd0, 12'd0, 12'd320, 12'd224);
        set_layout('0, 1'b1, 16'd100, 1'b1, 1'b0);
        send_screen(12'd0, 12'd0, 12'd320, 12'd224);
    endtask

    // Plane A spanning the full width or height leaves one window strip.
    task automatic test_window_strips();
        set_layout('0, 1'b0, 16'd64, 1'b1, 1'b0);
        send_screen(12'd0, 12'd0, 12'd320, 12'd224);
        send_screen(12'd5, 12'd7, 12'd320, 12'd224);
        set_layout(16'd100, 1'b1, '0, 1'b0, 1'b0);
        send_screen(12'd0, 12'd0, 12'd320, 12'd224);
        send_screen(12'd3, 12'd9, 12'd320, 12'd224);
    endtask

    // Corner layouts give two windows; the order depends on where plane A starts.
    task automatic test_window_pairs();
        set_layout(16'd128, 1'b1, 16'd96, 1'b1, 1'b0);
        send_screen(12'd0, 12'd0, 12'd320, 12'd224);
        send_screen(12'd8, 12'd16, 12'd320, 12'd224);
        set_layout(16'd200, 1'b0, 16'd150, 1'b0, 1'b1);
        send_screen(12'd0, 12'd0, 12'd320, 12'd224);
        send_screen('1, '1, '1, '1);
        send_screen('1, '0, '1, '0);
    endtask

    // Random screens over a series of layouts, extremes first; one phase
    // runs with neither side idling.
    task automatic test_random_layouts();
        for (int phase = 0; phase < 8; phase++) begin
            case (phase)
                0: set_layout('1, 1'b1, '1, 1'b1, 1'b1);
                1: set_layout('0, 1'b0, '0, 1'b0, 1'b0);
                default: set_layout(rand_split(), 1'($urandom_range(1)), rand_split(),
                                    1'($urandom_range(1)), 1'($urandom_range(1)));
            endcase
            no_idle = (phase == 3);
            repeat (16) send_random_screen();
        end
        no_idle = 1'b0;
    endtask

    // Output held off for a long stretch while screens keep coming.
    task automatic test_output_stall();
        set_layout(16'd128, 1'b1, 16'd96, 1'b0, 1'b1);
        hold_toggle <= ~hold_toggle;
        repeat (12) send_random_screen();
    endtask

    // Sender waits for the block to empty between bursts.
    task automatic test_sender_pause();
        set_layout(rand_split(), 1'b0, rand_split(), 1'b1, 1'b0);
        repeat (6) send_random_screen();
        drain_regions();
        repeat (6) send_random_screen();
    endtask

    // Long receiver hold-off, counted here in its own cycles.
    initial begin
        hold_left = 0;
        hold_seen = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_left != 0) begin
                hold_left <= hold_left - 1;
            end else if (hold_toggle != hold_seen) begin
                hold_left <= HOLD_CYCLES;
                hold_seen <= hold_toggle;
            end
        end
    end

    // Region receiver: drives ready and checks each beat against the oldest
    // expected region.
    initial begin
        t_region want;
        region_if.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && region_if.valid && region_if.ready) begin
                if (expected_regions.size() == 0) begin
                    $error("region beat arrived with no region expected");
                    failures++;
                end else begin
                    want = expected_regions.pop_front();
                    regions_checked++;
                    if (region_if.plane_id !== want.plane_id) begin
                        $error("plane_id: expected %0d, got %0d", want.plane_id,
                               region_if.plane_id);
                        failures++;
                    end
                    if (region_if.region_x !== want.rect.x) begin
                        $error("region_x: expected %0d, got %0d", want.rect.x,
                               region_if.region_x);
                        failures++;
                    end
                    if (region_if.region_y !== want.rect.y) begin
                        $error("region_y: expected %0d, got %0d", want.rect.y,
                               region_if.region_y);
                        failures++;
                    end
                    if (region_if.region_width !== want.rect.w) begin
                        $error("region_width: expected %0d, got %0d", want.rect.w,
                               region_if.region_width);
                        failures++;
                    end
                    if (region_if.region_height !== want.rect.h) begin
                        $error("region_height: expected %0d, got %0d", want.rect.h,
                               region_if.region_height);
                        failures++;
                    end
                    if (region_if.last_region !== want.last) begin
                        $error("last_region: expected %0d, got %0d", want.last,
                               region_if.last_region);
                        failures++;
                    end
                end
            end
            region_if.ready <= (hold_left == 0) && (no_idle || $urandom_range(99) >= 29);
        end
    end

    // Watchdog: too long without any beat on either channel ends the run.
    always @(posedge i_clk) begin
        if (!i_rst_n || (screen_if.valid && screen_if.ready) ||
            (region_if.valid && region_if.ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Watchdog: no beat for %0d cycles, %0d regions still owed",
                     quiet_cycles, expected_regions.size());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        i_rst_n                 = 1'b0;
        psel                    = 1'b0;
        penable                 = 1'b0;
        pwrite                  = 1'b0;
        paddr                   = '0;
        pwdata                  = '0;
        screen_if.valid         = 1'b0;
        screen_if.screen_x      = '0;
        screen_if.screen_y      = '0;
        screen_if.screen_width  = '0;
        screen_if.screen_height = '0;
        layout                  = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_layout();
        test_clamped_splits();
        test_empty_plane_a();
        test_window_strips();
        test_window_pairs();
        test_random_layouts();
        test_output_stall();
        test_sender_pause();

        drain_regions();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        $display("Sent %0d screens under %0d layouts; checked %0d regions,",
                 screens_sent, layouts_used, regions_checked);
        $display("%0d of the screens split the window into two rectangles.", window_pairs);
        if (failures == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
